// ----- rtl/core/ready_queue_min_select_top_defines.svh -----
// ============================================================================
// Ready queue min select: assertion macros
// Concurrent assertion helpers for the ready queue datapath.
// ============================================================================
`ifndef READY_QUEUE_MIN_SELECT_TOP_DEFINES_SVH
`define READY_QUEUE_MIN_SELECT_TOP_DEFINES_SVH

// Checks that a condition implies another one in the same cycle.
`define RQMS_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ready queue check failed");

// Checks that a condition implies another one in the following cycle.
`define RQMS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ready queue check failed");

`endif

// ----- rtl/core/rqms_pkg.sv -----
// ============================================================================
// Ready queue min select package
// Shared types, command and status codes and the key selection function.
// ============================================================================
`default_nettype none

package rqms_pkg;

   localparam logic [2:0] CMD_PUSH      = 3'd0;
   localparam logic [2:0] CMD_POP_HEAD  = 3'd1;
   localparam logic [2:0] CMD_POP_BURST = 3'd2;
   localparam logic [2:0] CMD_POP_REM   = 3'd3;
   localparam logic [2:0] CMD_POP_PRIO  = 3'd4;
   localparam logic [2:0] CMD_AGE       = 3'd5;
   localparam logic [2:0] CMD_CLEAR     = 3'd6;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   localparam logic [15:0] WAIT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [7:0]  tid;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [7:0]  prio;
      logic [15:0] wait_cnt;
   } rec_type;

   typedef struct packed {
      logic accept;
      logic scan_step;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic select_pop;
      logic scan_done;
      logic rsp_free;
   } ctrl_stat_type;

   function automatic logic [15:0] key_of(rec_type r, logic [2:0] cmd);
      logic [15:0] k;
      case (cmd)
         CMD_POP_BURST: k = r.burst;
         CMD_POP_REM:   k = r.remaining;
         default:       k = {8'd0, r.prio};
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rqms_req_if.sv -----
// ============================================================================
// Ready queue request channel
// Valid/ready channel carrying one queue command and its record.
// ============================================================================
`default_nettype none

interface rqms_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [7:0]  new_tid;
   logic [15:0] new_burst;
   logic [15:0] new_remaining;
   logic [7:0]  new_priority;
   logic [15:0] new_wait;

   modport source (output valid, cmd, new_tid, new_burst, new_remaining, new_priority,
                   new_wait, input ready);
   modport sink (input valid, cmd, new_tid, new_burst, new_remaining, new_priority,
                 new_wait, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rqms_rsp_if.sv -----
// ============================================================================
// Ready queue response channel
// Valid/ready channel carrying the outcome of one queue command.
// ============================================================================
`default_nettype none

interface rqms_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  out_tid;
   logic [15:0] out_burst;
   logic [15:0] out_remaining;
   logic [7:0]  out_priority;
   logic [15:0] out_wait;
   logic [4:0]  occupancy;

   modport source (output valid, status, out_tid, out_burst, out_remaining, out_priority,
                   out_wait, occupancy, input ready);
   modport sink (input valid, status, out_tid, out_burst, out_remaining, out_priority,
                 out_wait, occupancy, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rqms_ctrl.sv -----
// ============================================================================
// Ready queue controller
// Sequences request acceptance, the minimum scan and the queue update.
// ============================================================================
`default_nettype none

module rqms_ctrl import rqms_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire ctrl_stat_type stat,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.select_pop ? ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_EXEC;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_EXEC: begin
            if (stat.rsp_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/rqms_dp.sv -----
// ============================================================================
// Ready queue datapath
// Record cells, entry count, sequential minimum scan and response register.
// ============================================================================
`default_nettype none

`include "ready_queue_min_select_top_defines.svh"

module rqms_dp import rqms_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [2:0]   req_cmd,
   input  wire rec_type      req_rec,
   input  wire ctrl_cmd_type cmd,
   output ctrl_stat_type     stat,
   rqms_rsp_if.source        rsp
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   rec_type        cells_ff [DEPTH];
   rec_type        cells_in [DEPTH];
   logic [CW-1:0]  count_ff, count_in;
   logic [2:0]     cmd_ff, cmd_in;
   rec_type        new_ff, new_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [IW-1:0]  best_ff, best_in;
   logic [15:0]    bestkey_ff, bestkey_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     status_ff, status_in;
   rec_type        out_ff, out_in;
   logic [4:0]     occ_ff, occ_in;
   logic [15:0]    scan_key;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cells_ff   <= cells_in;
      cmd_ff     <= cmd_in;
      new_ff     <= new_in;
      idx_ff     <= idx_in;
      best_ff    <= best_in;
      bestkey_ff <= bestkey_in;
      status_ff  <= status_in;
      out_ff     <= out_in;
      occ_ff     <= occ_in;
   end

   assign scan_key = key_of(cells_ff[idx_ff[IW-1:0]], cmd_ff);

   always_comb begin
      cells_in     = cells_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      new_in       = new_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      bestkey_in   = bestkey_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      out_in       = out_ff;
      occ_in       = occ_ff;

      if (cmd.accept) begin
         cmd_in     = req_cmd;
         new_in     = req_rec;
         idx_in     = CW'(1);
         best_in    = '0;
         bestkey_in = key_of(cells_ff[0], req_cmd);
      end

      if (cmd.scan_step) begin
         if (scan_key < bestkey_ff) begin
            bestkey_in = scan_key;
            best_in    = idx_ff[IW-1:0];
         end
         idx_in = idx_ff + CW'(1);
      end

      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
         status_in    = STAT_OK;
         out_in       = '0;
         case (cmd_ff)
            CMD_PUSH: begin
               if (count_ff == CW'(DEPTH)) begin
                  status_in = STAT_FULL;
               end else begin
                  cells_in[count_ff[IW-1:0]] = new_ff;
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_POP_HEAD, CMD_POP_BURST, CMD_POP_REM, CMD_POP_PRIO: begin
               if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  out_in = cells_ff[best_ff];
                  for (int j = 0; j < DEPTH - 1; j++) begin
                     if (j >= int'(best_ff)) begin
                        cells_in[j] = cells_ff[j+1];
                     end
                  end
                  count_in = count_ff - CW'(1);
               end
            end
            CMD_AGE: begin
               for (int j = 0; j < DEPTH; j++) begin
                  if (j < int'(count_ff) && cells_ff[j].wait_cnt != WAIT_MAX) begin
                     cells_in[j].wait_cnt = cells_ff[j].wait_cnt + 16'd1;
                  end
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
         occ_in = 5'(count_in);
      end
   end

   assign stat.select_pop = (req_cmd == CMD_POP_BURST || req_cmd == CMD_POP_REM ||
                             req_cmd == CMD_POP_PRIO) && (count_ff != '0);
   assign stat.scan_done  = idx_ff >= count_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp.ready;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.out_tid       = out_ff.tid;
   assign rsp.out_burst     = out_ff.burst;
   assign rsp.out_remaining = out_ff.remaining;
   assign rsp.out_priority  = out_ff.prio;
   assign rsp.out_wait      = out_ff.wait_cnt;
   assign rsp.occupancy     = occ_ff;

   `RQMS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `RQMS_ASSERT_SAME(a_scan_in_range, clock, reset, cmd.scan_step, idx_ff < count_ff)
   `RQMS_ASSERT_SAME(a_exec_slot_free, clock, reset, cmd.exec, stat.rsp_free)
   `RQMS_ASSERT_NEXT(a_exec_gives_rsp, clock, reset, cmd.exec, rsp_valid_ff)

endmodule

`default_nettype wire

// ----- rtl/core/ready_queue_min_select_top.sv -----
// ============================================================================
// Ready queue min select
// Arrival-ordered thread queue with head pop and least-key selection pops.
// ============================================================================
// Channel    Dir  Carries
// req_chan   in   command plus the record to push
// rsp_chan   out  status, removed record and occupancy
//
// Push, pop head, age, clear and a pop on an empty queue skip the scan and go
// from the accept state straight to the execute state. A least-key pop first
// runs the one-compare-per-cycle scan over the record cells.
// Reset empties the queue; record contents are not cleared.
// A new request is taken while the previous response waits to be taken.
// ============================================================================
`default_nettype none

module ready_queue_min_select_top import rqms_pkg::*; #(
   parameter int DEPTH = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   rqms_req_if.sink  req_chan,
   rqms_rsp_if.source rsp_chan
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   rec_type       req_rec;

   assign req_rec.tid       = req_chan.new_tid;
   assign req_rec.burst     = req_chan.new_burst;
   assign req_rec.remaining = req_chan.new_remaining;
   assign req_rec.prio      = req_chan.new_priority;
   assign req_rec.wait_cnt  = req_chan.new_wait;

   rqms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rqms_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_cmd (req_chan.cmd),
      .req_rec (req_rec),
      .cmd     (cmd),
      .stat    (stat),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire
